/* rtl/core/lfs_pkg.sv */
// Shared types, constants and distance table for the likelihood field stamper.
`default_nettype none

package lfs_pkg;

    localparam int MAP_SIZE        = 512;
    localparam int TEMPLATE_RADIUS = 20;
    localparam int LEVELS          = 4;
    localparam int DIST_FRAC_BITS  = 4;

    localparam int ROW_W     = 9;
    localparam int PIX_W     = 8;
    localparam int ACT_W     = 2;
    localparam int LVL_W     = 2;
    localparam int DIST_W    = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_LEVELS = 1 << LVL_W;
    localparam int LOG_MAP    = $clog2(MAP_SIZE);
    localparam int COORD_W    = ((LOG_MAP > ROW_W) ? LOG_MAP : ROW_W) + 2;
    localparam int OFF_W      = $clog2(2 * TEMPLATE_RADIUS);
    localparam int ABS_W      = $clog2(TEMPLATE_RADIUS + 1);
    localparam int LUT_N      = ((TEMPLATE_RADIUS + 1) * (TEMPLATE_RADIUS + 2)) / 2;
    localparam int LUT_IDX_W  = $clog2(LUT_N);
    localparam int SWEEP_W    = 2 * LOG_MAP;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [ACT_W-1:0] ACT_STAMP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OCCUPIED_BELOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_SKIP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_DISTANCE   = 2'd2;

    localparam logic [PIX_W-1:0]  OCCUPIED_BELOW_RST = 8'd127;
    localparam logic [ROW_W-1:0]  BORDER_SKIP_RST    = 9'd25;
    localparam logic [DIST_W-1:0] FAR_DISTANCE_RST   = 9'd480;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [PIX_W-1:0] pixel;
        logic [LVL_W-1:0] level;
    } lfs_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              stamped;
        logic              read_ok;
    } lfs_out_t;

    typedef logic [LUT_N-1:0][DIST_W-1:0] dist_lut_t;

    function automatic logic [31:0] isqrt32(input logic [31:0] v);
        logic [31:0] res;
        logic [31:0] rem;
        logic [31:0] bitv;
        int          k;
        res  = '0;
        rem  = v;
        bitv = 32'h4000_0000;
        for (k = 0; k < 16; k++) begin
            if (bitv > rem) begin
                bitv = bitv >> 2;
            end
        end
        for (k = 0; k < 16; k++) begin
            if (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // round(sqrt(d2) * 2^frac), saturated
    function automatic logic [DIST_W-1:0] offset_length(input logic [31:0] d2);
        logic [31:0] s;
        logic [31:0] r;
        s = isqrt32((d2 << (2 * DIST_FRAC_BITS)) << 2);
        r = (s + 32'd1) >> 1;
        return (r > 32'(DIST_MAX)) ? DIST_MAX : r[DIST_W-1:0];
    endfunction

    // indexed by max*(max+1)/2 + min of the absolute offsets
    function automatic dist_lut_t build_dist_lut();
        dist_lut_t lut;
        int        hi;
        int        lo;
        int        k;
        lut = '0;
        for (hi = 0; hi <= TEMPLATE_RADIUS; hi++) begin
            for (lo = 0; lo <= hi; lo++) begin
                k = ((hi * (hi + 1)) >> 1) + lo;
                lut[k] = offset_length(32'(hi * hi + lo * lo));
            end
        end
        return lut;
    endfunction

    localparam dist_lut_t DIST_LUT = build_dist_lut();

endpackage

`default_nettype wire

/* rtl/core/lfs_ram.sv */
// Simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module lfs_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 9
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/likelihood_field_stamper.sv */
// Top level of the likelihood field stamper: sequencer, template walk and level stores.
`default_nettype none

// Keeps one distance store per pyramid level (sides 64, 128, 256 and 512 cells) and takes
// one request word at a time. A stamp of an occupied pixel walks the 40 x 40 offset
// template once, one offset per cycle, with all levels updated side by side through a
// read, compare and write on each level's RAM. A stamp that is not occupied, and the
// no-op code, go straight to the result; a read first fetches the stored distance.
// A clear sweeps every store, one entry per level per cycle, over the 262144 entries of
// the largest level. After reset the same sweep runs with the far value 480, and no
// request is accepted while it runs; configuration writes are taken throughout. Every
// request returns one result word.

module likelihood_field_stamper (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfs_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire lfs_pkg::lfs_in_t               req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output lfs_pkg::lfs_out_t                   rsp
);

    typedef enum logic [5:0] {
        ST_SWEEP = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WALK  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_RD    = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    localparam logic [lfs_pkg::OFF_W-1:0] RAD_U    = lfs_pkg::OFF_W'(lfs_pkg::TEMPLATE_RADIUS);
    localparam logic [lfs_pkg::OFF_W-1:0] OFF_LAST =
        lfs_pkg::OFF_W'(2 * lfs_pkg::TEMPLATE_RADIUS - 1);
    localparam logic signed [lfs_pkg::COORD_W-1:0] RAD_S =
        lfs_pkg::COORD_W'(lfs_pkg::TEMPLATE_RADIUS);
    localparam logic [lfs_pkg::COORD_W-1:0] MAP_U = lfs_pkg::COORD_W'(lfs_pkg::MAP_SIZE);
    localparam int TRI_W = 2 * lfs_pkg::ABS_W + 1;

    state_t                           state_reg, state_next;
    logic [lfs_pkg::PIX_W-1:0]        occ_reg;
    logic [lfs_pkg::ROW_W-1:0]        border_reg;
    logic [lfs_pkg::DIST_W-1:0]       far_reg;
    logic [lfs_pkg::OFF_W-1:0]        u_r_reg, u_r_next;
    logic [lfs_pkg::OFF_W-1:0]        u_c_reg, u_c_next;
    logic [lfs_pkg::SWEEP_W-1:0]      sweep_reg, sweep_next;
    logic [lfs_pkg::DIST_W-1:0]       fill_reg, fill_next;
    logic                             clr_rsp_reg, clr_rsp_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    lfs_pkg::lfs_out_t                rsp_reg, rsp_next;
    lfs_pkg::lfs_out_t                res_reg, res_next;
    lfs_pkg::lfs_in_t                 item_reg, item_next;
    logic                             rok_reg, rok_next;
    logic [lfs_pkg::DIST_W-1:0]       dist_reg;

    logic                             sweeping;
    logic                             hit;
    logic signed [lfs_pkg::COORD_W-1:0] dr_s, dc_s;
    logic [lfs_pkg::ABS_W-1:0]        abs_r, abs_c, hi, lo;
    logic [TRI_W-1:0]                 hi_ext, tri_w;
    logic [lfs_pkg::LUT_IDX_W-1:0]    lut_idx;
    logic [lfs_pkg::MAX_LEVELS-1:0]   rok_vec;
    logic [lfs_pkg::DIST_W-1:0]       rdata [lfs_pkg::MAX_LEVELS];

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign sweeping  = (state_reg == ST_SWEEP);

    assign hit = (req.pixel < occ_reg) && (req.row >= border_reg) && (req.col >= border_reg)
              && (lfs_pkg::COORD_W'(req.row) < MAP_U) && (lfs_pkg::COORD_W'(req.col) < MAP_U);

    // template offsets and their length
    assign dr_s = $signed(lfs_pkg::COORD_W'(u_r_reg)) - RAD_S;
    assign dc_s = $signed(lfs_pkg::COORD_W'(u_c_reg)) - RAD_S;
    assign abs_r = (u_r_reg >= RAD_U) ? lfs_pkg::ABS_W'(u_r_reg - RAD_U)
                                      : lfs_pkg::ABS_W'(RAD_U - u_r_reg);
    assign abs_c = (u_c_reg >= RAD_U) ? lfs_pkg::ABS_W'(u_c_reg - RAD_U)
                                      : lfs_pkg::ABS_W'(RAD_U - u_c_reg);
    assign hi      = (abs_r >= abs_c) ? abs_r : abs_c;
    assign lo      = (abs_r >= abs_c) ? abs_c : abs_r;
    assign hi_ext  = TRI_W'(hi);
    assign tri_w   = hi_ext * (hi_ext + 1'b1);
    assign lut_idx = lfs_pkg::LUT_IDX_W'(tri_w[TRI_W-1:1] + (TRI_W-1)'(lo));

    genvar l;
    generate
        for (l = 0; l < lfs_pkg::MAX_LEVELS; l++)
        begin : g_lvl
            if (l < lfs_pkg::LEVELS)
            begin : g_on
                localparam int SH = lfs_pkg::LEVELS - 1 - l;
                localparam int SB = lfs_pkg::LOG_MAP - SH;
                localparam int AW = 2 * SB;
                localparam logic signed [lfs_pkg::COORD_W-1:0] SIDE_S =
                    lfs_pkg::COORD_W'(1 << SB);
                localparam logic [lfs_pkg::COORD_W-1:0] SIDE_U = lfs_pkg::COORD_W'(1 << SB);

                logic signed [lfs_pkg::COORD_W-1:0] cr, cc, r, c;
                logic [lfs_pkg::COORD_W-1:0]        rr, rc;
                logic                               inb;
                logic [AW-1:0]                      walk_addr, req_addr, waddr_reg;
                logic [AW-1:0]                      waddr, raddr;
                logic                               wlive_reg, we;
                logic [lfs_pkg::DIST_W-1:0]         wdata, rd;

                assign cr = $signed(lfs_pkg::COORD_W'(item_reg.row >> SH));
                assign cc = $signed(lfs_pkg::COORD_W'(item_reg.col >> SH));
                assign r  = cr + dr_s;
                assign c  = cc + dc_s;
                assign inb = !r[lfs_pkg::COORD_W-1] && (r < SIDE_S)
                          && !c[lfs_pkg::COORD_W-1] && (c < SIDE_S);
                assign walk_addr = {r[SB-1:0], c[SB-1:0]};

                assign rr = lfs_pkg::COORD_W'(req.row);
                assign rc = lfs_pkg::COORD_W'(req.col);
                assign rok_vec[l] = (rr < SIDE_U) && (rc < SIDE_U);
                assign req_addr   = {rr[SB-1:0], rc[SB-1:0]};

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        wlive_reg <= 1'b0;
                    end
                    else
                    begin
                        wlive_reg <= (state_reg == ST_WALK) && inb;
                    end
                end

                always_ff @(posedge clk)
                begin
                    waddr_reg <= walk_addr;
                end

                // second half of read-compare-write
                assign we    = sweeping || (wlive_reg && (rd > dist_reg));
                assign waddr = sweeping ? sweep_reg[AW-1:0] : waddr_reg;
                assign wdata = sweeping ? fill_reg : dist_reg;
                assign raddr = (state_reg == ST_WALK) ? walk_addr : req_addr;

                lfs_ram #(
                    .ADDR_W (AW),
                    .DATA_W (lfs_pkg::DIST_W)
                ) u_store (
                    .clk   (clk),
                    .we    (we),
                    .waddr (waddr),
                    .wdata (wdata),
                    .raddr (raddr),
                    .rdata (rd)
                );

                assign rdata[l] = rd;
            end
            else
            begin : g_off
                assign rdata[l]   = '0;
                assign rok_vec[l] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        u_r_next       = u_r_reg;
        u_c_next       = u_c_reg;
        sweep_next     = sweep_reg;
        fill_next      = fill_reg;
        clr_rsp_next   = clr_rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        item_next      = item_reg;
        rok_next       = rok_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (&sweep_reg)
                begin
                    state_next = clr_rsp_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    res_next  = '0;
                    rok_next  = rok_vec[req.level];
                    unique case (req.action)
                        lfs_pkg::ACT_STAMP:
                        begin
                            if (hit)
                            begin
                                res_next.stamped = 1'b1;
                                u_r_next         = '0;
                                u_c_next         = '0;
                                state_next       = ST_WALK;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        lfs_pkg::ACT_READ:
                        begin
                            state_next = ST_RD;
                        end
                        lfs_pkg::ACT_CLEAR:
                        begin
                            fill_next    = far_reg;
                            sweep_next   = '0;
                            clr_rsp_next = 1'b1;
                            state_next   = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (u_r_reg == OFF_LAST)
                begin
                    u_r_next = '0;
                    if (u_c_reg == OFF_LAST)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        u_c_next = u_c_reg + 1'b1;
                    end
                end
                else
                begin
                    u_r_next = u_r_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_RD:
            begin
                res_next.read_ok  = rok_reg;
                res_next.distance = rok_reg ? rdata[item_reg.level] : '0;
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            u_r_reg       <= '0;
            u_c_reg       <= '0;
            sweep_reg     <= '0;
            fill_reg      <= lfs_pkg::FAR_DISTANCE_RST;
            clr_rsp_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            u_r_reg       <= u_r_next;
            u_c_reg       <= u_c_next;
            sweep_reg     <= sweep_next;
            fill_reg      <= fill_next;
            clr_rsp_reg   <= clr_rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= lfs_pkg::OCCUPIED_BELOW_RST;
            border_reg <= lfs_pkg::BORDER_SKIP_RST;
            far_reg    <= lfs_pkg::FAR_DISTANCE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lfs_pkg::REG_OCCUPIED_BELOW: occ_reg    <= cfg_data[lfs_pkg::PIX_W-1:0];
                lfs_pkg::REG_BORDER_SKIP:    border_reg <= cfg_data[lfs_pkg::ROW_W-1:0];
                lfs_pkg::REG_FAR_DISTANCE:   far_reg    <= cfg_data[lfs_pkg::DIST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        res_reg  <= res_next;
        item_reg <= item_next;
        rok_reg  <= rok_next;
        dist_reg <= lfs_pkg::DIST_LUT[lut_idx];
    end

endmodule

`default_nettype wire
